FILE: src/tqc_pkg.sv
// Package with the shared types, constants and codes of the timer queue.
`timescale 1ns / 1ps
`default_nettype none
package tqc_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int NEAR_FULL = (HEAP_DEPTH * 2) / 3;
    localparam int MAX_FIRE = 64;
    localparam int FIRE_W = $clog2(MAX_FIRE + 1);
    localparam int BUF_AW = $clog2(MAX_FIRE);
    localparam int GRP = 32;
    localparam int NGRP = (HEAP_DEPTH + GRP - 1) / GRP;
    localparam int PADDR_W = 3;
    localparam logic [9:0] MS_TO_US = 10'd1000;
    localparam logic [63:0] REL_MAX = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;

    localparam logic [1:0] OP_SCHED_ABS = 2'd0;
    localparam logic [1:0] OP_SCHED_REL = 2'd1;
    localparam logic [1:0] OP_CANCEL    = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_FIRE_LIMIT = '0;

    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] task_id;
        logic        cancelled;
    } t_entry;

    typedef struct packed {
        logic        ins;
        logic        pop;
        logic        can;
        logic [31:0] cancel_id;
        t_entry      new_entry;
    } t_cell_cmd;
endpackage
`default_nettype wire

FILE: src/tqc_if.sv
// Item channel interfaces for the input and result sides of the timer queue.
`timescale 1ns / 1ps
`default_nettype none
interface tqc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] time_value;
    logic [31:0] cancel_id;
    logic [63:0] now_us;
    modport source(output valid, opcode, time_value, cancel_id, now_us, input ready);
    modport sink(input valid, opcode, time_value, cancel_id, now_us, output ready);
endinterface

interface tqc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] task_number;
    logic [63:0] next_deadline;
    logic        near_full;
    logic        last;
    modport source(output valid, kind, task_number, next_deadline, near_full, last,
                   input ready);
    modport sink(input valid, kind, task_number, next_deadline, near_full, last,
                 output ready);
endinterface
`default_nettype wire

FILE: src/timer_queue_with_cancel.sv
// Top level of the timer queue: sequencer, sorted cell chain, fire buffer and APB register.
// Schedule absolute runs S_INS, S_EMIT; relative S_MUL, S_ADD, S_INS, S_EMIT; cancel S_CAN1,
// S_CAN2, S_CAN3, S_EMIT; a tick pops one entry per cycle, then S_RD, S_EMIT per fired id.
// Items are taken one at a time; the cell chain does one insert, pop or cancel per cycle.
// Synchronous active-low reset empties the queue, sets the next id to 1 and fire_limit to 64.
// No clearing pass is needed: the entry count alone marks which cells hold tasks.
`timescale 1ns / 1ps
`default_nettype none
module timer_queue_with_cancel (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    tqc_in_if.sink                           i_in,
    tqc_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tqc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import tqc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ADD, S_INS, S_CAN1, S_CAN2, S_CAN3, S_TICK, S_RD, S_EMIT
    } t_state;

    t_state          r_state;
    logic [63:0]     r_tv;
    logic [31:0]     r_cid;
    logic [63:0]     r_now;
    logic [63:0]     r_dl;
    logic [63:0]     r_prod;
    logic            r_ovf;
    logic [CNT_W-1:0] r_count;
    logic [31:0]     r_next_id;
    logic [6:0]      r_limit;
    logic [FIRE_W-1:0] r_nres;
    logic [FIRE_W-1:0] r_rd;
    logic [1:0]      r_kind;
    logic [31:0]     r_task;
    logic [NGRP-1:0] r_grp;
    logic            r_ov;
    logic [1:0]      r_o_kind;
    logic [31:0]     r_o_task;
    logic [63:0]     r_o_dl;
    logic            r_o_nf;
    logic            r_o_last;

    t_cell_cmd       w_cmd;
    t_entry          w_ent [HEAP_DEPTH];
    logic            w_lt [HEAP_DEPTH];
    logic [NGRP*GRP-1:0] w_hits;
    logic [HEAP_DEPTH-1:0] w_valid;
    t_entry          w_head;
    logic [64:0]     w_sum;
    logic [FIRE_W-1:0] w_lim;
    logic            w_due;
    logic            w_buf_we;
    logic [31:0]     w_buf_rd;
    logic            w_emit_last;
    logic            w_cfg_we;

    assign w_head = w_ent[0];
    assign w_sum = {1'b0, r_now} + {1'b0, r_prod};
    assign w_lim = (r_limit > 7'(MAX_FIRE)) ? FIRE_W'(MAX_FIRE) : FIRE_W'(r_limit);
    assign w_due = (r_count != '0) && (w_head.deadline <= r_now) && (r_nres < w_lim);
    assign w_buf_we = (r_state == S_TICK) && w_due && !w_head.cancelled;
    assign w_emit_last = (r_rd + FIRE_W'(1)) == r_nres;

    always_comb begin
        w_cmd = '0;
        w_cmd.cancel_id = r_cid;
        w_cmd.new_entry.deadline = r_dl;
        w_cmd.new_entry.task_id = r_next_id;
        w_cmd.new_entry.cancelled = 1'b0;
        w_cmd.ins = (r_state == S_INS) && (r_count < CNT_W'(HEAP_DEPTH));
        w_cmd.pop = (r_state == S_TICK) && w_due;
        w_cmd.can = (r_state == S_CAN1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < HEAP_DEPTH; gi++) begin : g_cell
            assign w_valid[gi] = r_count > CNT_W'(gi);
            tqc_cell u_cell (
                .i_clk     (i_clk),
                .i_valid   (w_valid[gi]),
                .i_cmd     (w_cmd),
                .i_left    ((gi == 0) ? w_cmd.new_entry : w_ent[(gi == 0) ? 0 : gi - 1]),
                .i_left_lt ((gi == 0) ? 1'b0 : w_lt[(gi == 0) ? 0 : gi - 1]),
                .i_right   ((gi == HEAP_DEPTH - 1) ? t_entry'('0) :
                            w_ent[(gi == HEAP_DEPTH - 1) ? gi : gi + 1]),
                .o_entry   (w_ent[gi]),
                .o_lt      (w_lt[gi]),
                .o_hit     (w_hits[gi])
            );
        end
        for (gi = HEAP_DEPTH; gi < NGRP * GRP; gi++) begin : g_pad
            assign w_hits[gi] = 1'b0;
        end
    endgenerate

    tqc_fire_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_buf_we),
        .i_wr_addr (r_nres[BUF_AW-1:0]),
        .i_wr_data (w_head.task_id),
        .i_rd_addr (r_rd[BUF_AW-1:0]),
        .o_rd_data (w_buf_rd)
    );

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= |w_hits[g*GRP +: GRP];
        end
    end

    assign w_cfg_we = psel && penable && pwrite && (paddr == ADDR_FIRE_LIMIT);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FIRE_LIMIT) ? {25'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_next_id <= 32'd1;
            r_limit <= 7'd64;
            r_ov <= 1'b0;
            r_nres <= '0;
            r_rd <= '0;
        end else begin
            if (w_cfg_we) begin
                r_limit <= pwdata[6:0];
            end
            if (r_ov && o_out.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_tv <= i_in.time_value;
                        r_cid <= i_in.cancel_id;
                        r_now <= i_in.now_us;
                        r_dl <= i_in.time_value;
                        r_nres <= '0;
                        r_rd <= '0;
                        case (i_in.opcode)
                            OP_SCHED_ABS: r_state <= S_INS;
                            OP_SCHED_REL: r_state <= S_MUL;
                            OP_CANCEL:    r_state <= S_CAN1;
                            default:      r_state <= S_TICK;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod <= r_tv * MS_TO_US;
                    r_ovf <= r_tv > REL_MAX;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_dl <= (r_ovf || w_sum[64]) ? 64'hFFFF_FFFF_FFFF_FFFF : w_sum[63:0];
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_next_id <= (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;
                    r_kind <= KIND_SCHED;
                    r_nres <= FIRE_W'(1);
                    if (w_cmd.ins) begin
                        r_count <= r_count + CNT_W'(1);
                        r_task <= r_next_id;
                    end else begin
                        r_task <= 32'd0;
                    end
                    r_state <= S_EMIT;
                end
                S_CAN1: r_state <= S_CAN2;
                S_CAN2: r_state <= S_CAN3;
                S_CAN3: begin
                    r_kind <= KIND_CANCEL;
                    r_task <= (|r_grp) ? r_cid : 32'd0;
                    r_nres <= FIRE_W'(1);
                    r_state <= S_EMIT;
                end
                S_TICK: begin
                    if (w_due) begin
                        r_count <= r_count - CNT_W'(1);
                        if (!w_head.cancelled) begin
                            r_nres <= r_nres + FIRE_W'(1);
                        end
                    end else if (r_nres == '0) begin
                        r_kind <= KIND_NONE;
                        r_task <= 32'd0;
                        r_nres <= FIRE_W'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_kind <= KIND_FIRED;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        r_o_kind <= r_kind;
                        r_o_task <= (r_kind == KIND_FIRED) ? w_buf_rd : r_task;
                        r_o_dl <= (r_count != '0) ? w_head.deadline : 64'hFFFF_FFFF_FFFF_FFFF;
                        r_o_nf <= r_count >= CNT_W'(NEAR_FULL);
                        r_o_last <= w_emit_last;
                        r_rd <= r_rd + FIRE_W'(1);
                        r_state <= w_emit_last ? S_IDLE : S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.kind = r_o_kind;
    assign o_out.task_number = r_o_task;
    assign o_out.next_deadline = r_o_dl;
    assign o_out.near_full = r_o_nf;
    assign o_out.last = r_o_last;
endmodule
`default_nettype wire

FILE: src/tqc_cell.sv
// One cell of the sorted timer chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module tqc_cell (
    input  wire logic               i_clk,
    input  wire logic               i_valid,
    input  wire tqc_pkg::t_cell_cmd i_cmd,
    input  wire tqc_pkg::t_entry    i_left,
    input  wire logic               i_left_lt,
    input  wire tqc_pkg::t_entry    i_right,
    output tqc_pkg::t_entry         o_entry,
    output logic                    o_lt,
    output logic                    o_hit
);
    import tqc_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_hit;
    logic   w_match;

    always_comb begin
        o_lt = !i_valid || (i_cmd.new_entry.deadline < r_ent.deadline) ||
               ((i_cmd.new_entry.deadline == r_ent.deadline) &&
                (i_cmd.new_entry.task_id < r_ent.task_id));
        w_match = i_valid && !r_ent.cancelled && (r_ent.task_id == i_cmd.cancel_id);
        n_ent = r_ent;
        if (i_cmd.ins) begin
            if (o_lt) begin
                n_ent = i_left_lt ? i_left : i_cmd.new_entry;
            end
        end else if (i_cmd.pop) begin
            n_ent = i_right;
        end else if (i_cmd.can && w_match) begin
            n_ent.cancelled = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_hit <= i_cmd.can && w_match;
    end

    assign o_entry = r_ent;
    assign o_hit = r_hit;
endmodule
`default_nettype wire

FILE: src/tqc_fire_buf.sv
// Buffer of fired task ids collected during one tick.
`timescale 1ns / 1ps
`default_nettype none
module tqc_fire_buf (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [tqc_pkg::BUF_AW-1:0] i_wr_addr,
    input  wire logic [31:0]                i_wr_data,
    input  wire logic [tqc_pkg::BUF_AW-1:0] i_rd_addr,
    output logic [31:0]                     o_rd_data
);
    import tqc_pkg::*;

    logic [31:0] r_mem [MAX_FIRE];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

FILE: src/tqc_checker.sv
// Port checker for the timer queue and the bind that attaches it.
`timescale 1ns / 1ps
`default_nettype none
module tqc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_out_kind,
    input wire logic [31:0] i_out_task,
    input wire logic        i_out_last
);
    import tqc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_SCHED || i_out_kind == KIND_CANCEL ||
                        i_out_kind == KIND_NONE) |-> i_out_last)
        else $error("single-result item without last");

    a_fired_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_FIRED) |-> (i_out_task != 32'd0))
        else $error("fired task with id zero");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the item was handled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind timer_queue_with_cancel tqc_checker u_tqc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_task  (o_out.task_number),
    .i_out_last  (o_out.last)
);
`default_nettype wire

FILE: tb/sv/tb_timer_queue_with_cancel.sv
// Self-checking testbench for the timer queue with cancel, with an item-level heap predictor.
`timescale 1ns / 1ps
module tb_timer_queue_with_cancel;
    import tqc_pkg::*;

    typedef struct {
        logic [1:0]  opcode;
        logic [63:0] time_value;
        logic [31:0] cancel_id;
        logic [63:0] now_us;
    } t_req;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] task_number;
        logic [63:0] next_deadline;
        logic        near_full;
        logic        last;
    } t_res;

    class timer_scoreboard;
        logic [63:0] dl [HEAP_DEPTH];
        logic [31:0] tk [HEAP_DEPTH];
        bit          cx [HEAP_DEPTH];
        int          count;
        logic [31:0] nid;
        logic [6:0]  flim;
        t_res        waiting[$];
        int          errors;

        function new();
            count = 0;
            nid = 1;
            flim = 7'd64;
            errors = 0;
        endfunction

        function bit earlier(int a, int b);
            if (dl[a] != dl[b]) return dl[a] < dl[b];
            return tk[a] < tk[b];
        endfunction

        function void swap(int a, int b);
            logic [63:0] d;
            logic [31:0] t;
            bit          c;
            d = dl[a]; t = tk[a]; c = cx[a];
            dl[a] = dl[b]; tk[a] = tk[b]; cx[a] = cx[b];
            dl[b] = d; tk[b] = t; cx[b] = c;
        endfunction

        function void sift_down(int i);
            int l;
            int c;
            forever begin
                l = 2 * i + 1;
                if (l >= count) break;
                c = l;
                if (l + 1 < count && earlier(l + 1, l)) c = l + 1;
                if (!earlier(c, i)) break;
                swap(c, i);
                i = c;
            end
        endfunction

        function logic [31:0] schedule_at(logic [63:0] deadline);
            logic [31:0] id;
            int i;
            int p;
            id = nid;
            nid = (nid == 32'hFFFF_FFFF) ? 32'd1 : nid + 32'd1;
            if (count >= HEAP_DEPTH) return 32'd0;
            dl[count] = deadline;
            tk[count] = id;
            cx[count] = 1'b0;
            count++;
            i = count - 1;
            while (i > 0) begin
                p = (i - 1) / 2;
                if (!earlier(i, p)) break;
                swap(i, p);
                i = p;
            end
            return id;
        endfunction

        function void note(t_req r);
            logic [1:0]  kinds[$];
            logic [31:0] ids[$];
            logic [63:0] p;
            logic [63:0] d;
            logic [31:0] id;
            bit          dead;
            int          lim;
            int          fired;
            t_res        e;
            kinds = {};
            ids = {};
            case (r.opcode)
                OP_SCHED_ABS: begin
                    kinds.push_back(KIND_SCHED);
                    ids.push_back(schedule_at(r.time_value));
                end
                OP_SCHED_REL: begin
                    if (r.time_value > REL_MAX) begin
                        d = '1;
                    end else begin
                        p = r.time_value * 64'(MS_TO_US);
                        d = (p > ~r.now_us) ? '1 : r.now_us + p;
                    end
                    kinds.push_back(KIND_SCHED);
                    ids.push_back(schedule_at(d));
                end
                OP_CANCEL: begin
                    id = 32'd0;
                    for (int i = 0; i < count; i++) begin
                        if (tk[i] == r.cancel_id && !cx[i]) begin
                            cx[i] = 1'b1;
                            id = r.cancel_id;
                            break;
                        end
                    end
                    kinds.push_back(KIND_CANCEL);
                    ids.push_back(id);
                end
                default: begin
                    lim = (flim > MAX_FIRE) ? MAX_FIRE : flim;
                    fired = 0;
                    while (count > 0 && dl[0] <= r.now_us && fired < lim) begin
                        id = tk[0];
                        dead = cx[0];
                        count--;
                        if (count > 0) begin
                            dl[0] = dl[count]; tk[0] = tk[count]; cx[0] = cx[count];
                            sift_down(0);
                        end
                        if (!dead) begin
                            kinds.push_back(KIND_FIRED);
                            ids.push_back(id);
                            fired++;
                        end
                    end
                    if (kinds.size() == 0) begin
                        kinds.push_back(KIND_NONE);
                        ids.push_back(32'd0);
                    end
                end
            endcase
            for (int k = 0; k < kinds.size(); k++) begin
                e.kind = kinds[k];
                e.task_number = ids[k];
                e.next_deadline = (count > 0) ? dl[0] : '1;
                e.near_full = (count >= NEAR_FULL);
                e.last = (k == kinds.size() - 1);
                waiting.push_back(e);
            end
        endfunction

        function void check(t_res g);
            t_res e;
            if (waiting.size() == 0) begin
                $error("unexpected result item kind=%0d task=%0d", g.kind, g.task_number);
                errors++;
                return;
            end
            e = waiting.pop_front();
            if (g.kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, g.kind);
                errors++;
            end
            if (g.task_number !== e.task_number) begin
                $error("task_number: expected %0d, got %0d", e.task_number, g.task_number);
                errors++;
            end
            if (g.next_deadline !== e.next_deadline) begin
                $error("next_deadline: expected %h, got %h", e.next_deadline, g.next_deadline);
                errors++;
            end
            if (g.near_full !== e.near_full) begin
                $error("near_full: expected %0d, got %0d", e.near_full, g.near_full);
                errors++;
            end
            if (g.last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, g.last);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    tqc_in_if            in_if();
    tqc_out_if           out_if();

    timer_queue_with_cancel uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if.sink), .o_out(out_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    timer_scoreboard sb = new();
    int          accepted = 0;
    int          burst_left = 0;
    bit          hold = 0;
    logic [63:0] tnow = 64'd0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("tb_timer_queue_with_cancel failed");
        $finish;
    end

    initial begin
        wait (accepted >= 150);
        @(posedge i_clk);
        hold = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold = 1'b0;
    end

    initial begin
        int stall_left;
        int cyc;
        t_res g;
        stall_left = 0;
        cyc = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && out_if.valid && out_if.ready) begin
                g.kind = out_if.kind;
                g.task_number = out_if.task_number;
                g.next_deadline = out_if.next_deadline;
                g.near_full = out_if.near_full;
                g.last = out_if.last;
                sb.check(g);
            end
            if (hold) begin
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if ((cyc / 300) % 2 == 1 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send(logic [1:0] op, logic [63:0] tv, logic [31:0] cid, logic [63:0] now);
        t_req r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        r.opcode = op;
        r.time_value = tv;
        r.cancel_id = cid;
        r.now_us = now;
        in_if.valid <= 1'b1;
        in_if.opcode <= op;
        in_if.time_value <= tv;
        in_if.cancel_id <= cid;
        in_if.now_us <= now;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note(r);
        accepted++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.waiting.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_fire_limit(logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_FIRE_LIMIT;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.flim = v[6:0];
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        logic [63:0] tv;
        logic [63:0] now;
        logic [31:0] cid;
        int pick;
        tnow = tnow + $urandom_range(0, 2000);
        now = ($urandom_range(0, 15) == 0) ? rand64() : tnow;
        cid = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            tv = ($urandom_range(0, 15) == 0) ? rand64() : tnow + $urandom_range(0, 6000);
            send(OP_SCHED_ABS, tv, cid, now);
        end else if (pick < 55) begin
            tv = ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 6));
            send(OP_SCHED_REL, tv, cid, now);
        end else if (pick < 70) begin
            if ($urandom_range(0, 7) != 0) cid = sb.nid - $urandom_range(1, 20);
            send(OP_CANCEL, rand64(), cid, now);
        end else begin
            send(OP_TICK, rand64(), cid, now);
        end
    endtask

    initial begin
        logic [31:0] id;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_if.valid <= 1'b0;
        in_if.opcode <= OP_TICK;
        in_if.time_value <= '0;
        in_if.cancel_id <= '0;
        in_if.now_us <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_TICK, '0, '0, '1);
        send(OP_SCHED_ABS, '0, '0, '0);
        send(OP_SCHED_ABS, '1, '1, '1);
        send(OP_SCHED_ABS, 64'd500, '0, '0);
        send(OP_SCHED_ABS, 64'd500, '0, '0);
        send(OP_SCHED_REL, '0, '0, '0);
        send(OP_SCHED_REL, '1, '0, '0);
        send(OP_SCHED_REL, REL_MAX, '0, 64'd1);
        send(OP_SCHED_REL, 64'd5, '0, 64'hFFFF_FFFF_FFFF_F000);
        id = sb.nid - 32'd3;
        send(OP_CANCEL, '0, id, '0);
        send(OP_CANCEL, '0, id, '0);
        send(OP_CANCEL, '0, 32'd0, '0);
        send(OP_CANCEL, '0, '1, '0);
        send(OP_TICK, '0, '0, 64'd500);
        send(OP_TICK, '0, '0, '1);
        wait_idle();

        write_fire_limit(32'd1);
        for (int i = 0; i < 4; i++) send(OP_SCHED_ABS, 64'(i), '0, '0);
        send(OP_CANCEL, '0, sb.nid - 32'd4, '0);
        send(OP_TICK, '0, '0, '1);
        send(OP_TICK, '0, '0, '1);
        wait_idle();
        write_fire_limit(32'd0);
        send(OP_TICK, '0, '0, '1);
        wait_idle();
        write_fire_limit(32'd127);
        send(OP_TICK, '0, '0, '1);
        wait_idle();
        write_fire_limit(32'd64);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_fire_limit(32'd64);
                1: write_fire_limit(32'd1);
                2: write_fire_limit($urandom_range(2, 63));
                3: write_fire_limit(32'd0);
                default: write_fire_limit($urandom_range(65, 127));
            endcase
            for (int i = 0; i < 60; i++) random_item();
            wait_idle();
        end
        send(OP_TICK, '0, '0, '1);
        wait_idle();

        if (sb.errors == 0 && sb.waiting.size() == 0) begin
            $display("tb_timer_queue_with_cancel passed");
        end else begin
            $display("tb_timer_queue_with_cancel failed");
        end
        $finish;
    end
endmodule

FILE: timer_queue_with_cancel.f
src/tqc_pkg.sv
src/tqc_if.sv
src/tqc_cell.sv
src/tqc_fire_buf.sv
src/timer_queue_with_cancel.sv
src/tqc_checker.sv
tb/sv/tb_timer_queue_with_cancel.sv
